### design/point_gravity_euler_step_core_assert.svh
// Assertion macros for the Euler step core.
`ifndef POINT_GRAVITY_EULER_STEP_CORE_ASSERT_SVH
`define POINT_GRAVITY_EULER_STEP_CORE_ASSERT_SVH

// Assert that an antecedent implies a consequent in the next cycle.
`define PGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Assert that an antecedent implies a consequent in the same cycle.
`define PGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

### design/pge_pkg.sv
`timescale 1ns / 1ps
package pge_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned DIV_W = 64;
    localparam int unsigned SQRT_BITS = 34;

    localparam logic [CFG_IDX_W-1:0] REG_ATTR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASS = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] particle_mass;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic coincident;
        logic saturated;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic [DATA_W:0] ux;
        logic [DATA_W:0] uy;
        logic neg_x;
        logic neg_y;
        logic coincident;
        logic no_accel;
        logic [2*DATA_W-1:0] sm;
    } t_work;

    function automatic logic signed [DATA_W-1:0] sat_s(input logic signed [DATA_W+1:0] v,
                                                      output logic clip);
        logic signed [DATA_W+1:0] hi;
        logic signed [DATA_W+1:0] lo;
        hi = {3'b000, {(DATA_W-1){1'b1}}};
        lo = {3'b111, {(DATA_W-1){1'b0}}};
        clip = 1'b0;
        if (v > hi) begin
            clip = 1'b1;
            sat_s = hi[DATA_W-1:0];
        end else if (v < lo) begin
            clip = 1'b1;
            sat_s = lo[DATA_W-1:0];
        end else begin
            sat_s = v[DATA_W-1:0];
        end
    endfunction
endpackage

### design/pge_stream_if.sv
`timescale 1ns / 1ps
interface pge_stream_if #(parameter int unsigned W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### design/pge_front.sv
`timescale 1ns / 1ps
module pge_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [pge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pge_pkg::DATA_W-1:0] i_cfg_data,
    pge_stream_if.sink s_in,
    output logic o_push,
    output pge_pkg::t_work o_work,
    input  logic i_room
);
    import pge_pkg::*;

    logic signed [DATA_W-1:0] r_ax;
    logic signed [DATA_W-1:0] r_ay;
    logic [DATA_W-1:0] r_str;
    logic [DATA_W-1:0] r_mass;
    logic [2*DATA_W-1:0] sm;
    t_in_item in_item;
    logic signed [DATA_W:0] dx;
    logic signed [DATA_W:0] dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_str <= '0;
            r_mass <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ATTR_X: r_ax <= i_cfg_data;
                REG_ATTR_Y: r_ay <= i_cfg_data;
                REG_STRENGTH: r_str <= i_cfg_data;
                REG_MASS: r_mass <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sm = r_str * r_mass;

    assign in_item = s_in.data;
    assign s_in.ready = i_room;
    assign o_push = s_in.valid && i_room;
    assign dx = (DATA_W+1)'(r_ax) - (DATA_W+1)'(in_item.pos_x);
    assign dy = (DATA_W+1)'(r_ay) - (DATA_W+1)'(in_item.pos_y);

    always_comb begin
        o_work.pos_x = in_item.pos_x;
        o_work.pos_y = in_item.pos_y;
        o_work.vel_x = in_item.vel_x;
        o_work.vel_y = in_item.vel_y;
        o_work.neg_x = dx[DATA_W];
        o_work.neg_y = dy[DATA_W];
        o_work.ux = dx[DATA_W] ? (DATA_W+1)'(-dx) : (DATA_W+1)'(dx);
        o_work.uy = dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
        o_work.coincident = (dx == '0) && (dy == '0);
        o_work.no_accel = (in_item.particle_mass == '0) || (sm == '0);
        o_work.sm = sm;
    end
endmodule

### design/pge_queue.sv
`timescale 1ns / 1ps
module pge_queue #(
    parameter int unsigned DEPTH = pge_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  pge_pkg::t_work i_work,
    output logic o_room,
    output logic o_valid,
    output pge_pkg::t_work o_work,
    input  logic i_pop
);
    import pge_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_work r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0] r_cnt;
    logic do_pop;

    assign o_room = r_cnt < (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_work = r_mem[r_rp];
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end
endmodule

### design/pge_back.sv
`timescale 1ns / 1ps
module pge_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  pge_pkg::t_work i_work,
    output logic o_pop,
    pge_stream_if.source m_out
);
    import pge_pkg::*;

    // Sequencer: IDLE, SQRT (34 steps), RR, DIVA, DIVX, DIVY (128 steps each), FIN, OUT.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_RR = 3'd2;
    localparam logic [2:0] ST_DIVA = 3'd3;
    localparam logic [2:0] ST_DIVX = 3'd4;
    localparam logic [2:0] ST_DIVY = 3'd5;
    localparam logic [2:0] ST_FIN = 3'd6;
    localparam logic [2:0] ST_OUT = 3'd7;

    logic [2:0] r_st;
    t_work r_w;
    logic [6:0] r_cnt;
    logic [67:0] r_v;
    logic [33:0] r_res;
    logic [128:0] r_num;
    logic [128:0] r_rem;
    logic [127:0] r_den;
    logic [63:0] r_q;
    logic r_qlost;
    logic [31:0] r_a;
    logic [31:0] r_mx;
    logic [31:0] r_my;
    logic r_clip;
    logic r_mul_ph;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    t_out_item r_out;
    logic r_ovalid;

    logic [33:0] cand;
    logic [128:0] rem_sh;
    logic [128:0] rem_sub;
    logic [63:0] q_nxt;
    logic lost_nxt;
    logic q_over;
    logic [31:0] q_sat;
    logic signed [DATA_W+1:0] cx;
    logic signed [DATA_W+1:0] cy;
    logic signed [DATA_W+1:0] sx;
    logic signed [DATA_W+1:0] sy;
    logic signed [DATA_W-1:0] nvx;
    logic signed [DATA_W-1:0] nvy;
    logic signed [DATA_W-1:0] npx;
    logic signed [DATA_W-1:0] npy;
    logic c0;
    logic c1;
    logic c2;
    logic c3;
    logic out_free;

    assign cand = r_res | (34'd1 << r_cnt[5:0]);
    assign rem_sh = {r_rem[127:0], r_num[128]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_nxt = {r_q[62:0], !rem_sub[128]};
    assign lost_nxt = r_qlost | r_q[63];
    assign q_over = lost_nxt || (q_nxt[63:32] != '0);
    assign q_sat = q_over ? 32'hFFFF_FFFF : q_nxt[31:0];
    assign out_free = !r_ovalid || m_out.ready;
    assign o_pop = (r_st == ST_IDLE) && i_valid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;

    always_comb begin
        cx = r_w.neg_x ? -(DATA_W+2)'(r_mx) : (DATA_W+2)'(r_mx);
        cy = r_w.neg_y ? -(DATA_W+2)'(r_my) : (DATA_W+2)'(r_my);
        if (r_w.no_accel) begin
            cx = '0;
            cy = '0;
        end
        sx = (DATA_W+2)'(r_w.vel_x) + cx;
        sy = (DATA_W+2)'(r_w.vel_y) + cy;
        nvx = sat_s(sx, c0);
        nvy = sat_s(sy, c1);
        npx = sat_s((DATA_W+2)'(r_w.pos_x) + (DATA_W+2)'(nvx), c2);
        npy = sat_s((DATA_W+2)'(r_w.pos_y) + (DATA_W+2)'(nvy), c3);
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_w <= i_work;
                r_v <= 68'(i_work.ux * i_work.ux) + 68'(i_work.uy * i_work.uy);
                r_res <= '0;
                r_cnt <= 7'd33;
                r_clip <= 1'b0;
                r_mul_ph <= 1'b0;
            end
            ST_SQRT: begin
                // two 34x17 partial products per candidate
                if (!r_mul_ph) begin
                    r_pa <= 64'(cand * cand[16:0]);
                    r_pb <= 64'(cand * cand[33:17]);
                    r_mul_ph <= 1'b1;
                end else begin
                    r_mul_ph <= 1'b0;
                    if (r_v >= ({4'd0, r_pa} + ({4'd0, r_pb} << 17))) r_res <= cand;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            ST_RR: begin
                r_num <= 129'({r_w.sm, 16'd0}) << 1;
                r_den <= 128'(r_res * r_res);
                r_rem <= '0;
                r_q <= '0;
                r_qlost <= 1'b0;
                r_cnt <= 7'd127;
            end
            ST_DIVA, ST_DIVX, ST_DIVY: begin
                if (r_cnt == '0) begin
                    r_rem <= '0;
                    r_q <= '0;
                    r_qlost <= 1'b0;
                    r_cnt <= 7'd127;
                    r_den <= 128'(r_res);
                    r_clip <= r_clip | q_over;
                    if (r_st == ST_DIVA) begin
                        r_a <= q_sat;
                        r_num <= 129'(q_sat * r_w.ux) << 1;
                    end else if (r_st == ST_DIVX) begin
                        r_mx <= q_sat;
                        r_num <= 129'(r_a * r_w.uy) << 1;
                    end else begin
                        r_my <= q_sat;
                    end
                end else begin
                    r_num <= r_num << 1;
                    r_q <= q_nxt;
                    r_qlost <= lost_nxt;
                    r_rem <= rem_sub[128] ? rem_sh : rem_sub;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            default: ;
        endcase
        if (r_st == ST_OUT && out_free) begin
            r_out.new_vel_x <= r_w.coincident ? r_w.vel_x : nvx;
            r_out.new_vel_y <= r_w.coincident ? r_w.vel_y : nvy;
            r_out.new_pos_x <= r_w.coincident ? r_w.pos_x : npx;
            r_out.new_pos_y <= r_w.coincident ? r_w.pos_y : npy;
            r_out.coincident <= r_w.coincident;
            r_out.saturated <= !r_w.coincident && (c0 | c1 | c2 | c3 |
                               (!r_w.no_accel && r_clip));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_st <= (i_work.coincident || i_work.no_accel) ? ST_OUT : ST_SQRT;
                end
                ST_SQRT: if (r_mul_ph && r_cnt == '0) r_st <= ST_RR;
                ST_RR: r_st <= ST_DIVA;
                ST_DIVA: if (r_cnt == '0) r_st <= ST_DIVX;
                ST_DIVX: if (r_cnt == '0) r_st <= ST_DIVY;
                ST_DIVY: if (r_cnt == '0) r_st <= ST_FIN;
                ST_FIN: r_st <= ST_OUT;
                ST_OUT: if (out_free) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

### design/point_gravity_euler_step_core.sv
`timescale 1ns / 1ps
// Point attractor Euler step.
// Channels: s_in carries one particle per transfer (position, velocity,
// mass); m_out returns one updated particle per input, in order.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write attractor x, y, strength
// and mass; write only while no particle is in flight.
// Front: computes the offset and classifies the particle, then pushes it
// into a four-entry queue; it keeps taking particles while the queue has room.
// Back: one sequencer shared by all particles, one at a time: a 34-step square
// root and three 128-step restoring divides.
// Path: coincident, massless or zero-pull particles go from the queue through
// the IDLE and OUT states to the output register; others also pass SQRT, RR,
// DIVA, DIVX, DIVY and FIN. The back end takes a new particle from the queue
// only once the last one has left OUT.
// Reset: clears the queue, the sequencer state, the output valid and the config
// registers (attractor at origin, strength and mass zero).
// A stalled receiver holds the output register; the back end then waits
// and the queue fills before s_in.ready drops.
module point_gravity_euler_step_core #(
    parameter int unsigned QDEPTH = pge_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [pge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pge_pkg::DATA_W-1:0] i_cfg_data,
    pge_stream_if.sink s_in,
    pge_stream_if.source m_out
);
    import pge_pkg::*;

    logic push;
    logic room;
    logic q_valid;
    logic pop;
    t_work f_work;
    t_work q_work;

    pge_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_in, .o_push(push), .o_work(f_work), .i_room(room)
    );

    pge_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_work(f_work), .o_room(room),
        .o_valid(q_valid), .o_work(q_work), .i_pop(pop)
    );

    pge_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_work(q_work), .o_pop(pop), .m_out
    );
endmodule

### design/pge_checker.sv
`timescale 1ns / 1ps
`include "point_gravity_euler_step_core_assert.svh"
module pge_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [pge_pkg::DATA_W*4+1:0] out_data
);
    `PGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_data))
    `PGE_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `PGE_ASSERT_NOW(a_coinc_flags, i_clk, i_rst_n, out_valid && out_data[1], !out_data[0])
    `PGE_ASSERT_NOW(a_ready_known, i_clk, i_rst_n, 1'b1, !$isunknown(in_ready))
endmodule

bind point_gravity_euler_step_core pge_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);

### verif/point_gravity_euler_step_core_checker.sv
`timescale 1ns / 1ps
module point_gravity_euler_step_core_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [pge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pge_pkg::DATA_W-1:0] i_cfg_data,
    pge_stream_if in_ch,
    pge_stream_if out_ch,
    output int o_errors,
    output int o_pending
);
    import pge_pkg::*;

    logic signed [31:0] attr_x, attr_y;
    logic [31:0] strength, attr_mass;
    t_out_item expected_particles[$];

    function automatic logic [31:0] clip32(input logic signed [63:0] v, inout bit clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_out_item advance_particle(input t_in_item it);
        logic signed [33:0] dx, dy;
        logic [32:0] ux, uy;
        logic [127:0] dist_sq, r, cand, num, q, a, mx, my;
        logic signed [63:0] cx, cy, vx, vy, px, py;
        bit clip;
        t_out_item o;
        clip = 1'b0;
        dx = $signed({attr_x[31], attr_x[31], attr_x})
             - $signed({it.pos_x[31], it.pos_x[31], it.pos_x});
        dy = $signed({attr_y[31], attr_y[31], attr_y})
             - $signed({it.pos_y[31], it.pos_y[31], it.pos_y});
        o = '0;
        if (dx == 0 && dy == 0) begin
            o.new_pos_x = it.pos_x;
            o.new_pos_y = it.pos_y;
            o.new_vel_x = it.vel_x;
            o.new_vel_y = it.vel_y;
            o.coincident = 1'b1;
            return o;
        end
        cx = 0;
        cy = 0;
        if (it.particle_mass != 0) begin
            ux = dx < 0 ? 33'(-dx) : 33'(dx);
            uy = dy < 0 ? 33'(-dy) : 33'(dy);
            dist_sq = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
            r = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = r | (128'd1 << b);
                if (cand * cand <= dist_sq) r = cand;
            end
            num = (128'(strength) * 128'(attr_mass)) << 16;
            q = num / (r * r);
            if (q > 128'hFFFFFFFF) begin
                clip = 1'b1;
                a = 128'hFFFFFFFF;
            end else begin
                a = q;
            end
            mx = (a * 128'(ux)) / r;
            if (mx > 128'hFFFFFFFF) begin
                clip = 1'b1;
                mx = 128'hFFFFFFFF;
            end
            my = (a * 128'(uy)) / r;
            if (my > 128'hFFFFFFFF) begin
                clip = 1'b1;
                my = 128'hFFFFFFFF;
            end
            cx = $signed({32'd0, mx[31:0]});
            cy = $signed({32'd0, my[31:0]});
            if (dx < 0) cx = -cx;
            if (dy < 0) cy = -cy;
        end
        vx = $signed(64'(it.vel_x)) + cx;
        vy = $signed(64'(it.vel_y)) + cy;
        o.new_vel_x = clip32(vx, clip);
        o.new_vel_y = clip32(vy, clip);
        px = $signed(64'(it.pos_x)) + $signed(64'(o.new_vel_x));
        py = $signed(64'(it.pos_y)) + $signed(64'(o.new_vel_y));
        o.new_pos_x = clip32(px, clip);
        o.new_pos_y = clip32(py, clip);
        o.saturated = clip;
        return o;
    endfunction

    assign o_pending = expected_particles.size();

    always @(posedge i_clk) begin
        t_out_item exp_item, got_item;
        if (!i_rst_n) begin
            attr_x <= '0;
            attr_y <= '0;
            strength <= '0;
            attr_mass <= '0;
            expected_particles.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ATTR_X: attr_x <= i_cfg_data;
                    REG_ATTR_Y: attr_y <= i_cfg_data;
                    REG_STRENGTH: strength <= i_cfg_data;
                    REG_MASS: attr_mass <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_particles.push_back(advance_particle(t_in_item'(in_ch.data)));
            if (out_ch.valid && out_ch.ready) begin
                got_item = t_out_item'(out_ch.data);
                if (expected_particles.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("unexpected transfer: %h", got_item);
                end else begin
                    exp_item = expected_particles.pop_front();
                    if (got_item.new_pos_x !== exp_item.new_pos_x
                        || got_item.new_pos_y !== exp_item.new_pos_y
                        || got_item.new_vel_x !== exp_item.new_vel_x
                        || got_item.new_vel_y !== exp_item.new_vel_y
                        || got_item.coincident !== exp_item.coincident
                        || got_item.saturated !== exp_item.saturated) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: exp pos %h %h vel %h %h c%b s%b,",
                                     exp_item.new_pos_x, exp_item.new_pos_y,
                                     exp_item.new_vel_x, exp_item.new_vel_y,
                                     exp_item.coincident, exp_item.saturated,
                                     " got pos %h %h vel %h %h c%b s%b",
                                     got_item.new_pos_x, got_item.new_pos_y,
                                     got_item.new_vel_x, got_item.new_vel_y,
                                     got_item.coincident, got_item.saturated);
                    end
                end
            end
        end
    end
endmodule

### verif/point_gravity_euler_step_core_test.sv
`timescale 1ns / 1ps
module point_gravity_euler_step_core_test;
    import pge_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_data;
    int errors, pending;
    int burst_left;
    logic signed [31:0] cur_ax, cur_ay;

    pge_stream_if #(.W($bits(t_in_item))) in_ch();
    pge_stream_if #(.W($bits(t_out_item))) out_ch();

    point_gravity_euler_step_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_in(in_ch),
        .m_out(out_ch)
    );

    point_gravity_euler_step_core_checker checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .o_errors(errors),
        .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // stall on a randomly chosen ready pattern, picked anew when its run count ends
    int stall_mode;
    int stall_cnt;
    initial begin
        out_ch.ready = 1'b0;
        stall_mode = 0;
        stall_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (stall_cnt == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_cnt = $urandom_range(50, 400);
            end
            stall_cnt--;
            case (stall_mode)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = ($urandom_range(0, 3) != 0);
                2: out_ch.ready = ($urandom_range(0, 1) != 0);
                default: out_ch.ready = ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    initial begin
        #100ms;
        $display("point_gravity_euler_step_core_test NOT OK");
        $finish;
    end

    task automatic send_particle(input t_in_item it);
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid = 1'b1;
        in_ch.data = it;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_ATTR_X) cur_ax = val;
        if (idx == REG_ATTR_Y) cur_ay = val;
    endtask

    function automatic logic [31:0] near_attr(input logic [31:0] base);
        logic [31:0] off;
        off = $urandom & ((32'd1 << $urandom_range(0, 30)) - 1);
        return $urandom_range(0, 1) ? base + off : base - off;
    endfunction

    function automatic t_in_item random_particle();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            it.pos_x = near_attr(cur_ax);
            it.pos_y = near_attr(cur_ay);
        end else if (pick < 13) begin
            it.pos_x = cur_ax;
            it.pos_y = cur_ay;
        end else begin
            it.pos_x = $urandom;
            it.pos_y = $urandom;
        end
        if ($urandom_range(0, 2) == 0) begin
            it.vel_x = $urandom;
            it.vel_y = $urandom;
        end else begin
            it.vel_x = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
            it.vel_y = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
        end
        it.particle_mass = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
        return it;
    endfunction

    task automatic directed_set();
        send_particle('{cur_ax, cur_ay, 32'sh7FFFFFFF, 32'sh80000000, 32'h10000});
        send_particle('{cur_ax, cur_ay, 32'sh00012345, -32'sh1, 32'd0});
        send_particle('{cur_ax + 1, cur_ay, 32'sh0, 32'sh0, 32'hFFFFFFFF});
        send_particle('{cur_ax, cur_ay - 1, 32'sh0, 32'sh0, 32'd1});
        send_particle('{cur_ax + 32'h10000, cur_ay, 32'sh100, 32'sh0, 32'd0});
        send_particle('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'd5});
        send_particle('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'd5});
        send_particle('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd0});
    endtask

    task automatic random_set(input int n);
        for (int k = 0; k < n; k++) send_particle(random_particle());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        burst_left = 0;
        cur_ax = '0;
        cur_ay = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_set();
        random_set(100);

        write_reg(REG_STRENGTH, 32'h00010000);
        write_reg(REG_MASS, 32'h00010000);
        directed_set();
        random_set(450);

        write_reg(REG_ATTR_X, 32'h80000000);
        write_reg(REG_ATTR_Y, 32'h7FFFFFFF);
        write_reg(REG_STRENGTH, 32'hFFFFFFFF);
        write_reg(REG_MASS, 32'hFFFFFFFF);
        directed_set();
        random_set(350);

        write_reg(REG_ATTR_X, 32'h7FFFFFFF);
        write_reg(REG_ATTR_Y, 32'h80000000);
        write_reg(REG_STRENGTH, 32'd1);
        write_reg(REG_MASS, 32'd0);
        directed_set();
        random_set(100);

        for (int p = 0; p < 4; p++) begin
            write_reg(REG_ATTR_X, $urandom);
            write_reg(REG_ATTR_Y, $urandom);
            write_reg(REG_STRENGTH, $urandom >> $urandom_range(0, 31));
            write_reg(REG_MASS, $urandom >> $urandom_range(0, 31));
            random_set(140);
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("point_gravity_euler_step_core_test OK");
        end else begin
            $display("point_gravity_euler_step_core_test NOT OK");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/pge_pkg.sv
design/pge_stream_if.sv
design/pge_front.sv
design/pge_queue.sv
design/pge_back.sv
design/point_gravity_euler_step_core.sv
design/pge_checker.sv
verif/point_gravity_euler_step_core_checker.sv
verif/point_gravity_euler_step_core_test.sv
